FILE: sv/hashed_transposition_table_defines.svh
// assertion macros for the hashed transposition table
`ifndef HASHED_TRANSPOSITION_TABLE_DEFINES_SVH
`define HASHED_TRANSPOSITION_TABLE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define HTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define HTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define HTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define HTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/htt_pkg.sv
// shared types and constants for the hashed transposition table
package htt_pkg;

	localparam int DEF_IDX_W  = 16;
	localparam int SCORE_W    = 16;
	localparam int BOARD_BITS = 64;
	localparam int DEPTH_BITS = SCORE_W - 2;

	// depth 0, value unknown
	localparam logic [SCORE_W-1:0] MISS_SCORE = SCORE_W'(1);

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_STORE  = 1'b1
	} op_t;

	// sideband that travels with the board through the hash pipeline
	typedef struct packed {
		op_t                op;
		logic [SCORE_W-1:0] score;
	} item_t;

endpackage

FILE: sv/htt_hash.sv
// four-stage pipelined 64-bit integer hash with sideband
module htt_hash (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [htt_pkg::BOARD_BITS-1:0]      board,
	input  htt_pkg::item_t                      in_item,
	output logic                                out_valid,
	output logic [htt_pkg::BOARD_BITS-1:0]      hash,
	output htt_pkg::item_t                      out_item
);

	localparam int W = htt_pkg::BOARD_BITS;

	logic [W-1:0] k_s1, k_s2, k_s3, k_s4;
	logic         v_s1, v_s2, v_s3, v_s4;
	htt_pkg::item_t it_s1, it_s2, it_s3, it_s4;

	logic [W-1:0] x2, x3, x4;

	always_comb begin
		// k ^ (k >> 24), then * 265
		x2 = k_s1 ^ (k_s1 >> 24);
		// k ^ (k >> 14), then * 21
		x3 = k_s2 ^ (k_s2 >> 14);
		// k ^ (k >> 28), then + (k << 31)
		x4 = k_s3 ^ (k_s3 >> 28);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		k_s1  <= (~board) + (board << 21);
		k_s2  <= x2 + (x2 << 3) + (x2 << 8);
		k_s3  <= x3 + (x3 << 2) + (x3 << 4);
		k_s4  <= x4 + (x4 << 31);
		it_s1 <= in_item;
		it_s2 <= it_s1;
		it_s3 <= it_s2;
		it_s4 <= it_s3;
	end

	assign out_valid = v_s4;
	assign hash      = k_s4;
	assign out_item  = it_s4;

endmodule

FILE: sv/hashed_transposition_table.sv
// hashed transposition table, direct-mapped, depth-preferred replacement
// pipeline: a lookup's result strobes on done after the hash stages, the table access stage and the result register
// throughput: one transaction per cycle while busy is low; hash pipeline feeds a read-first table port
// reset: table is swept to zero, one entry a cycle, over every entry in turn with busy high
// the receiver cannot stall: done is a one-cycle strobe
`include "hashed_transposition_table_defines.svh"

module hashed_transposition_table #(
	parameter int IDX_W = htt_pkg::DEF_IDX_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            operation,
	input  logic [htt_pkg::BOARD_BITS-1:0]  board,
	input  logic [htt_pkg::SCORE_W-1:0]     new_score,
	output logic                            done,
	output logic                            hit,
	output logic [htt_pkg::SCORE_W-1:0]     found_score
);

	localparam int SB      = htt_pkg::SCORE_W;
	localparam int TAG_W   = htt_pkg::BOARD_BITS - IDX_W;
	localparam int ENTRY_W = TAG_W + SB;
	localparam int DEPTH   = 1 << IDX_W;

	// clearing sweep
	logic             clearing_q;
	logic [IDX_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign busy = clearing_q;

	// hash front end
	logic                           in_take;
	htt_pkg::item_t                 in_item;
	logic                           v_s4;
	logic [htt_pkg::BOARD_BITS-1:0] h_s4;
	htt_pkg::item_t                 it_s4;

	assign in_take        = start && !busy;
	assign in_item.op     = htt_pkg::op_t'(operation);
	assign in_item.score  = new_score;

	htt_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_take),
		.board     (board),
		.in_item   (in_item),
		.out_valid (v_s4),
		.hash      (h_s4),
		.out_item  (it_s4)
	);

	logic [IDX_W-1:0] raddr;
	assign raddr = h_s4[IDX_W-1:0];

	// table access stage
	logic               v_s5;
	htt_pkg::item_t     it_s5;
	logic [IDX_W-1:0]   addr_s5;
	logic [TAG_W-1:0]   tag_s5;
	logic               fwd_s5;
	logic [ENTRY_W-1:0] fwd_data_s5;
	logic [ENTRY_W-1:0] rd_s5;
	logic               lookup_s5;

	logic [ENTRY_W-1:0]             entry;
	logic                           match;
	logic [htt_pkg::DEPTH_BITS-1:0] old_depth, new_depth;
	logic                           st_we;
	logic [ENTRY_W-1:0]             st_wdata;
	logic                           mem_we;
	logic [IDX_W-1:0]               mem_waddr;
	logic [ENTRY_W-1:0]             mem_wdata;

	assign lookup_s5 = v_s5 && (it_s5.op == htt_pkg::OP_LOOKUP);

	always_comb begin
		entry     = fwd_s5 ? fwd_data_s5 : rd_s5;
		match     = entry[ENTRY_W-1:SB] == tag_s5;
		old_depth = entry[SB-1:2];
		new_depth = it_s5.score[SB-1:2];
		st_we     = v_s5 && (it_s5.op == htt_pkg::OP_STORE) &&
		            (match || (old_depth <= new_depth));
		st_wdata  = {tag_s5, it_s5.score};
		mem_we    = clearing_q || st_we;
		mem_waddr = clearing_q ? clr_addr_q : addr_s5;
		mem_wdata = clearing_q ? '0 : st_wdata;
	end

	logic [ENTRY_W-1:0] mem [DEPTH];

	// read-first port: a same-cycle write to the read address is forwarded below
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_s5 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		it_s5       <= it_s4;
		addr_s5     <= raddr;
		tag_s5      <= h_s4[htt_pkg::BOARD_BITS-1:IDX_W];
		fwd_s5      <= st_we && (addr_s5 == raddr);
		fwd_data_s5 <= st_wdata;
	end

	// result register
	logic          done_q;
	logic          hit_q;
	logic [SB-1:0] found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= lookup_s5;
		end
	end

	always_ff @(posedge clk) begin
		hit_q   <= match;
		found_q <= match ? entry[SB-1:0] : htt_pkg::MISS_SCORE;
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign found_score = found_q;

	`HTT_ASSERT_NEXT(a_lookup_gives_done, clk, arst_n, lookup_s5, done)
	`HTT_ASSERT_NOW(a_done_from_lookup, clk, arst_n, done, $past(lookup_s5))
	`HTT_ASSERT_NOW(a_no_work_while_clearing, clk, arst_n, clearing_q, !v_s5 && !done)
	`HTT_ASSERT_NOW(a_miss_score, clk, arst_n, done && !hit, found_score == htt_pkg::MISS_SCORE)

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the hashed transposition table
module testbench;

	localparam int TBITS        = htt_pkg::DEF_IDX_W;
	localparam int SCW          = htt_pkg::SCORE_W;
	localparam int TABLE_SIZE   = 1 << TBITS;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOT_SLOTS    = 12;
	localparam int HOT_TAGS     = 3;
	localparam int RANDOM_ITEMS = 1630;

	typedef struct packed {
		logic           hit;
		logic [SCW-1:0] score;
	} lookup_result_t;

	class score_table_shadow;
		bit [63:0] entries [TABLE_SIZE];
		lookup_result_t expected_lookups[$];
		int mismatches;
		int lookups;
		int hits;
		int stores;
		int dropped;

		function bit [63:0] wang_mix(bit [63:0] k);
			k = (~k) + (k << 21);
			k = k ^ (k >> 24);
			k = k * 64'd265;
			k = k ^ (k >> 14);
			k = k * 64'd21;
			k = k ^ (k >> 28);
			k = k + (k << 31);
			return k;
		endfunction

		// multiplicative inverse mod 2^64 by newton iteration
		function bit [63:0] odd_inverse(bit [63:0] a);
			bit [63:0] x;
			x = a;
			repeat (6) x = x * (64'd2 - a * x);
			return x;
		endfunction

		function bit [63:0] undo_xorshift(bit [63:0] h, int s);
			bit [63:0] y;
			y = h;
			repeat (64 / s + 1) y = h ^ (y >> s);
			return y;
		endfunction

		// board whose hash lands on the given slot with the given tag
		function bit [63:0] board_for(bit [63:0] tag, int slot);
			bit [63:0] k;
			k = (tag << TBITS) | 64'(slot);
			k = k * odd_inverse(64'd1 + (64'd1 << 31));
			k = undo_xorshift(k, 28);
			k = k * odd_inverse(64'd21);
			k = undo_xorshift(k, 14);
			k = k * odd_inverse(64'd265);
			k = undo_xorshift(k, 24);
			k = (k + 64'd1) * odd_inverse((64'd1 << 21) - 64'd1);
			return k;
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 25)
				$display("error at %0t: %s", $realtime, msg);
		endtask

		task note_transaction(htt_pkg::op_t op, bit [63:0] brd, bit [SCW-1:0] sc);
			bit [63:0] h;
			bit [63:0] tag;
			bit [63:0] entry;
			int slot;
			bit match;
			lookup_result_t res;
			h = wang_mix(brd);
			slot = int'(h & 64'(TABLE_SIZE - 1));
			tag = h >> TBITS;
			entry = entries[slot];
			match = (entry >> SCW) == tag;
			if (op == htt_pkg::OP_LOOKUP) begin
				res.hit = match;
				res.score = match ? entry[SCW-1:0] : htt_pkg::MISS_SCORE;
				expected_lookups.push_back(res);
				lookups++;
				if (match)
					hits++;
			end else begin
				stores++;
				// depth-preferred: keep a deeper entry of another position
				if (match || (entry[SCW-1:0] >> 2) <= (sc >> 2))
					entries[slot] = (tag << SCW) | 64'(sc);
				else
					dropped++;
			end
		endtask

		task check_result(logic got_hit, logic [SCW-1:0] got_score);
			lookup_result_t want;
			if (expected_lookups.size() == 0) begin
				report($sformatf("lookup result hit=%b score=%h with none pending",
					got_hit, got_score));
			end else begin
				want = expected_lookups.pop_front();
				if (got_hit !== want.hit)
					report($sformatf("hit %b, expected %b", got_hit, want.hit));
				if (got_score !== want.score)
					report($sformatf("found_score %h, expected %h", got_score, want.score));
			end
		endtask
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic                           operation;
	logic [htt_pkg::BOARD_BITS-1:0] board;
	logic [SCW-1:0]                 new_score;
	logic                           done;
	logic                           hit;
	logic [SCW-1:0]                 found_score;

	score_table_shadow shadow;
	int cycles = 0;
	int hot_slot [HOT_SLOTS];
	bit [63:0] hot_tag [HOT_SLOTS][HOT_TAGS];

	hashed_transposition_table u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.board       (board),
		.new_score   (new_score),
		.done        (done),
		.hit         (hit),
		.found_score (found_score)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done !== 1'b0)
				shadow.check_result(hit, found_score);
			if (start && busy === 1'b0)
				shadow.note_transaction(htt_pkg::op_t'(operation), board, new_score);
		end
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d lookups still pending", cycles,
			shadow.expected_lookups.size());
		$display("Mismatches found");
		$finish;
	end

	// one transaction: hold start until the table takes it
	task automatic send_item(htt_pkg::op_t op, bit [63:0] brd, bit [SCW-1:0] sc);
		start <= 1'b1;
		operation <= op;
		board <= brd;
		new_score <= sc;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic pause_cycle();
		start <= 1'b0;
		board <= {$urandom, $urandom};
		@(posedge clk);
	endtask

	function automatic bit [SCW-1:0] random_score();
		if ($urandom_range(99) < 8)
			return SCW'($urandom);
		return {htt_pkg::DEPTH_BITS'($urandom_range(7)), 2'($urandom)};
	endfunction

	initial begin
		int slot_a;
		bit [63:0] tag_x;
		bit [63:0] tag_y;
		bit [63:0] tag_z;
		bit [63:0] brd;
		int k;
		int quiet_from;
		bit quiet;

		arst_n = 1'b0;
		start = 1'b0;
		operation = htt_pkg::OP_LOOKUP;
		board = '0;
		new_score = '0;
		shadow = new();

		slot_a = $urandom_range(TABLE_SIZE - 1);
		tag_x = ({$urandom, $urandom} >> TBITS) | 64'd1;
		tag_y = tag_x ^ 64'd2;
		tag_z = tag_x ^ 64'd4;
		for (int i = 0; i < HOT_SLOTS; i++) begin
			hot_slot[i] = $urandom_range(TABLE_SIZE - 1);
			for (int j = 0; j < HOT_TAGS; j++)
				hot_tag[i][j] = {$urandom, $urandom} >> TBITS;
			// an untouched entry reads as tag zero, score zero
			if (i < 4)
				hot_tag[i][0] = '0;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, replacement rules, empty entries, back to back
		send_item(htt_pkg::OP_LOOKUP, 64'd0, 16'hffff);
		send_item(htt_pkg::OP_LOOKUP, '1, 16'h0000);
		send_item(htt_pkg::OP_LOOKUP, shadow.board_for(64'd0, slot_a), 16'h1234);
		send_item(htt_pkg::OP_STORE, shadow.board_for(tag_x, slot_a), {14'd5, 2'd2});
		send_item(htt_pkg::OP_LOOKUP, shadow.board_for(tag_x, slot_a), 16'h0);
		send_item(htt_pkg::OP_STORE, shadow.board_for(tag_y, slot_a), {14'd3, 2'd1});
		send_item(htt_pkg::OP_LOOKUP, shadow.board_for(tag_y, slot_a), 16'h0);
		send_item(htt_pkg::OP_LOOKUP, shadow.board_for(tag_x, slot_a), 16'h0);
		send_item(htt_pkg::OP_STORE, shadow.board_for(tag_y, slot_a), {14'd5, 2'd3});
		send_item(htt_pkg::OP_LOOKUP, shadow.board_for(tag_x, slot_a), 16'h0);
		send_item(htt_pkg::OP_LOOKUP, shadow.board_for(tag_y, slot_a), 16'h0);
		send_item(htt_pkg::OP_STORE, shadow.board_for(tag_y, slot_a), {14'd1, 2'd0});
		send_item(htt_pkg::OP_LOOKUP, shadow.board_for(tag_y, slot_a), 16'h0);
		send_item(htt_pkg::OP_STORE, shadow.board_for(tag_z, slot_a), 16'hffff);
		send_item(htt_pkg::OP_LOOKUP, shadow.board_for(tag_z, slot_a), 16'h0);
		send_item(htt_pkg::OP_STORE, shadow.board_for(64'd0, slot_a), 16'h0000);
		send_item(htt_pkg::OP_LOOKUP, shadow.board_for(64'd0, slot_a), 16'h0);
		send_item(htt_pkg::OP_STORE, '1, 16'hffff);
		send_item(htt_pkg::OP_LOOKUP, '1, 16'h0);
		send_item(htt_pkg::OP_STORE, 64'd0, 16'h0000);
		send_item(htt_pkg::OP_LOOKUP, 64'd0, 16'hffff);
		send_item(htt_pkg::OP_STORE, shadow.board_for(tag_z, slot_a), {14'd0, 2'd1});
		send_item(htt_pkg::OP_LOOKUP, shadow.board_for(tag_z, slot_a), 16'h0);

		quiet_from = $urandom_range(400, 900);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= quiet_from) && (i < quiet_from + 300);
			if (!quiet)
				while ($urandom_range(99) < 37)
					pause_cycle();
			if ($urandom_range(99) < 75) begin
				// contention on a few slots with a few positions each
				k = $urandom_range(HOT_SLOTS - 1);
				brd = shadow.board_for(hot_tag[k][$urandom_range(HOT_TAGS - 1)], hot_slot[k]);
				send_item(htt_pkg::op_t'($urandom_range(1)), brd, random_score());
			end else begin
				send_item(htt_pkg::op_t'($urandom_range(1)), {$urandom, $urandom},
					SCW'($urandom));
			end
		end
		start <= 1'b0;

		while (shadow.expected_lookups.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("ran %0d lookups (%0d hits) and %0d stores (%0d kept the deeper entry)",
			shadow.lookups, shadow.hits, shadow.stores, shadow.dropped);
		$display("%0d mismatching fields over %0d cycles", shadow.mismatches, cycles);
		if (shadow.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/htt_pkg.sv
sv/htt_hash.sv
sv/hashed_transposition_table.sv
dv/testbench.sv
